/* src/rmlu_pkg.sv */
// Package for the recursive multicore lock unit.
// It holds the request and response types, the operation and status codes and the
// statistic selectors. It depends on nothing.
`default_nettype none

package rmlu_pkg;

  // Number of cores that the one-bit core field can name.
  localparam int unsigned CoreIds = 2;

  // Operation codes carried in the mode field.
  typedef enum logic [2:0] {
    ModeEnter      = 3'd0,
    ModeLeave      = 3'd1,
    ModeAbandon    = 3'd2,
    ModeSuspend    = 3'd3,
    ModeResume     = 3'd4,
    ModeReadStat   = 3'd5,
    ModeClearStats = 3'd6
  } mode_e;

  // Response status codes.
  typedef enum logic [1:0] {
    StatusDone    = 2'd0,
    StatusBusy    = 2'd1,
    StatusIllegal = 2'd2
  } status_e;

  // Statistic selectors for a read.
  typedef enum logic [3:0] {
    StatAcquire    = 4'd0,
    StatContention = 4'd1,
    StatRecursion  = 4'd2,
    StatMaxDepth   = 4'd3,
    StatHold       = 4'd4,
    StatWait       = 4'd5,
    StatDetach     = 4'd6,
    StatBadSuspend = 4'd7,
    StatBadUnlock  = 4'd8,
    StatOwner      = 4'd9,
    StatCoreDepth  = 4'd10
  } stat_sel_e;

  // One lock request.
  typedef struct packed {
    logic [2:0]  mode;
    logic        core;
    logic [31:0] now_us;
    logic [7:0]  resume_level;
    logic        mask_in;
    logic [3:0]  stat_select;
  } lock_req_t;

  // One lock response.
  typedef struct packed {
    logic [1:0]  status;
    logic        held_by_caller;
    logic [1:0]  owner_word;
    logic [7:0]  caller_depth;
    logic [7:0]  suspended_depth;
    logic        restore_mask_valid;
    logic        restore_mask;
    logic [31:0] stat_value;
  } lock_rsp_t;

  // Snapshot of the lock state for checking.
  typedef struct packed {
    logic [1:0]         owner;
    logic [CoreIds-1:0] depth_nz;
  } lock_view_t;

endpackage

`default_nettype wire

/* src/rmlu_in_reg.sv */
// Input register of the recursive multicore lock unit.
// It holds one request until the lock logic takes it. Depends on rmlu_pkg.
`default_nettype none

module rmlu_in_reg (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire rmlu_pkg::lock_req_t in_req_i,
  input  wire logic               take_i,
  output logic                    valid_o,
  output rmlu_pkg::lock_req_t     req_o
);
  import rmlu_pkg::*;

  logic      valid_q, valid_d;
  lock_req_t req_q;
  logic      load;

  // The register refills whenever it is empty or its request moves on.
  assign in_stall_o = valid_q && !take_i;
  assign load       = in_valid_i && !in_stall_o;
  assign valid_d    = load ? 1'b1 : (take_i ? 1'b0 : valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // The payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load) begin
      req_q <= in_req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

`default_nettype wire

/* src/rmlu_core.sv */
// Lock state and next-state logic of the recursive multicore lock unit.
// It holds owner, per-core records and statistics and forms the response.
// Depends on rmlu_pkg.
`default_nettype none

module rmlu_core #(
  parameter int unsigned CORES    = 2,
  parameter int unsigned MAX_NEST = 255
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                fire_i,
  input  wire rmlu_pkg::lock_req_t req_i,
  output rmlu_pkg::lock_rsp_t      rsp_o,
  output rmlu_pkg::lock_view_t     view_o
);
  import rmlu_pkg::*;

  // Only cores that the core field can name get a record.
  localparam int unsigned Slots    = (CORES < CoreIds) ? CORES : CoreIds;
  localparam logic [7:0]  DepthCap = 8'((MAX_NEST < 255) ? MAX_NEST : 255);

  typedef struct packed {
    logic [31:0] acquire;
    logic [31:0] contention;
    logic [31:0] recursion;
    logic [7:0]  deepest;
    logic [31:0] longest_hold;
    logic [31:0] longest_wait;
    logic [31:0] detached;
    logic [31:0] bad_suspend;
    logic [31:0] bad_unlock;
  } stats_t;

  logic [1:0]  owner_q, owner_d;
  logic [7:0]  depth_q [Slots], depth_d [Slots];
  logic        mask_q  [Slots], mask_d  [Slots];
  logic [31:0] acqt_q  [Slots], acqt_d  [Slots];
  logic [31:0] wst_q   [Slots], wst_d   [Slots];
  logic        wf_q    [Slots], wf_d    [Slots];
  stats_t      stats_q, stats_d;

  // Caller's record as read, and as it will be written back.
  logic [7:0]  c_depth, n_depth;
  logic        c_mask, n_mask;
  logic [31:0] c_acqt, n_acqt;
  logic [31:0] c_wst, n_wst;
  logic        c_wf, n_wf;

  logic        core_ok, is_owner, do_acq, resume_set;
  logic [1:0]  token;
  logic [31:0] held_time, waited;
  logic [7:0]  resume_cap;
  lock_rsp_t   rsp;

  // Read the caller's record.
  always_comb begin
    c_depth = '0;
    c_mask  = 1'b0;
    c_acqt  = '0;
    c_wst   = '0;
    c_wf    = 1'b0;
    for (int s = 0; s < Slots; s++) begin
      if (int'(req_i.core) == s) begin
        c_depth = depth_q[s];
        c_mask  = mask_q[s];
        c_acqt  = acqt_q[s];
        c_wst   = wst_q[s];
        c_wf    = wf_q[s];
      end
    end
  end

  assign core_ok    = int'(req_i.core) < int'(CORES);
  assign token      = {1'b0, req_i.core} + 2'd1;
  assign is_owner   = owner_q == token;
  assign held_time  = req_i.now_us - c_acqt;
  assign waited     = c_wf ? (req_i.now_us - c_wst) : 32'd0;
  assign resume_cap = (req_i.resume_level < DepthCap) ? req_i.resume_level : DepthCap;

  // Operation decode and state update for one request.
  always_comb begin
    owner_d    = owner_q;
    stats_d    = stats_q;
    n_depth    = c_depth;
    n_mask     = c_mask;
    n_acqt     = c_acqt;
    n_wst      = c_wst;
    n_wf       = c_wf;
    do_acq     = 1'b0;
    resume_set = 1'b0;
    rsp        = '0;
    rsp.status = StatusDone;

    if (core_ok) begin
      unique case (req_i.mode)
        ModeEnter: begin
          if (is_owner) begin
            if (c_depth < DepthCap) begin
              n_depth = c_depth + 8'd1;
            end
            if (n_depth > stats_d.deepest) begin
              stats_d.deepest = n_depth;
            end
            stats_d.recursion = stats_q.recursion + 32'd1;
          end else begin
            do_acq = 1'b1;
          end
        end
        ModeLeave: begin
          if (!is_owner || c_depth == 8'd0) begin
            stats_d.bad_unlock = stats_q.bad_unlock + 32'd1;
            rsp.status         = StatusIllegal;
          end else begin
            n_depth = c_depth - 8'd1;
            if (c_depth == 8'd1) begin
              if (held_time > stats_q.longest_hold) begin
                stats_d.longest_hold = held_time;
              end
              owner_d                = '0;
              rsp.restore_mask_valid = 1'b1;
              rsp.restore_mask       = c_mask;
            end
          end
        end
        ModeAbandon: begin
          if (is_owner) begin
            n_depth = '0;
            owner_d = '0;
          end
        end
        ModeSuspend: begin
          if (c_depth == 8'd0 || !is_owner) begin
            stats_d.bad_suspend = stats_q.bad_suspend + 32'd1;
            rsp.status          = StatusIllegal;
          end else begin
            if (held_time > stats_q.longest_hold) begin
              stats_d.longest_hold = held_time;
            end
            n_depth             = '0;
            stats_d.detached    = stats_q.detached + 32'd1;
            owner_d             = '0;
            rsp.suspended_depth = c_depth;
          end
        end
        ModeResume: begin
          if (req_i.resume_level == 8'd0 || is_owner) begin
            stats_d.bad_suspend = stats_q.bad_suspend + 32'd1;
            rsp.status          = StatusIllegal;
          end else begin
            do_acq     = 1'b1;
            resume_set = 1'b1;
          end
        end
        ModeReadStat: begin
          unique case (req_i.stat_select)
            StatAcquire:    rsp.stat_value = stats_q.acquire;
            StatContention: rsp.stat_value = stats_q.contention;
            StatRecursion:  rsp.stat_value = stats_q.recursion;
            StatMaxDepth:   rsp.stat_value = {24'd0, stats_q.deepest};
            StatHold:       rsp.stat_value = stats_q.longest_hold;
            StatWait:       rsp.stat_value = stats_q.longest_wait;
            StatDetach:     rsp.stat_value = stats_q.detached;
            StatBadSuspend: rsp.stat_value = stats_q.bad_suspend;
            StatBadUnlock:  rsp.stat_value = stats_q.bad_unlock;
            StatOwner:      rsp.stat_value = {30'd0, owner_q};
            StatCoreDepth:  rsp.stat_value = {24'd0, c_depth};
            default:        rsp.stat_value = '0;
          endcase
        end
        ModeClearStats: begin
          stats_d = '0;
        end
        default: begin
        end
      endcase

      // Acquisition attempt by a core that does not own the lock.
      if (do_acq) begin
        if (owner_q != 2'd0) begin
          rsp.status = StatusBusy;
          if (!c_wf) begin
            n_wf  = 1'b1;
            n_wst = req_i.now_us;
          end
        end else begin
          if (waited > stats_q.longest_wait) begin
            stats_d.longest_wait = waited;
          end
          if (c_wf) begin
            stats_d.contention = stats_q.contention + 32'd1;
          end
          n_wf            = 1'b0;
          owner_d         = token;
          n_depth         = 8'd1;
          n_mask          = req_i.mask_in;
          n_acqt          = req_i.now_us;
          stats_d.acquire = stats_q.acquire + 32'd1;
          if (stats_q.deepest == 8'd0) begin
            stats_d.deepest = 8'd1;
          end
          if (resume_set && req_i.resume_level > 8'd1) begin
            n_depth = resume_cap;
            if (resume_cap > stats_d.deepest) begin
              stats_d.deepest = resume_cap;
            end
          end
        end
      end

      rsp.held_by_caller = owner_d == token;
      rsp.owner_word     = owner_d;
      rsp.caller_depth   = n_depth;
    end else begin
      // A core without a record is refused and not counted.
      rsp.status     = StatusIllegal;
      rsp.owner_word = owner_q;
    end
  end

  // Write the caller's record back.
  always_comb begin
    for (int s = 0; s < Slots; s++) begin
      if (core_ok && int'(req_i.core) == s) begin
        depth_d[s] = n_depth;
        mask_d[s]  = n_mask;
        acqt_d[s]  = n_acqt;
        wst_d[s]   = n_wst;
        wf_d[s]    = n_wf;
      end else begin
        depth_d[s] = depth_q[s];
        mask_d[s]  = mask_q[s];
        acqt_d[s]  = acqt_q[s];
        wst_d[s]   = wst_q[s];
        wf_d[s]    = wf_q[s];
      end
    end
  end

  // State registers advance once per request taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owner_q <= '0;
      stats_q <= '0;
      for (int s = 0; s < Slots; s++) begin
        depth_q[s] <= '0;
        mask_q[s]  <= 1'b0;
        acqt_q[s]  <= '0;
        wst_q[s]   <= '0;
        wf_q[s]    <= 1'b0;
      end
    end else if (fire_i) begin
      owner_q <= owner_d;
      stats_q <= stats_d;
      for (int s = 0; s < Slots; s++) begin
        depth_q[s] <= depth_d[s];
        mask_q[s]  <= mask_d[s];
        acqt_q[s]  <= acqt_d[s];
        wst_q[s]   <= wst_d[s];
        wf_q[s]    <= wf_d[s];
      end
    end
  end

  // Lock view for the checks at the top level.
  always_comb begin
    view_o.owner    = owner_q;
    view_o.depth_nz = '0;
    for (int s = 0; s < Slots; s++) begin
      view_o.depth_nz[s] = depth_q[s] != 8'd0;
    end
  end

  assign rsp_o = rsp;

endmodule

`default_nettype wire

/* src/rmlu_out_reg.sv */
// Result register of the recursive multicore lock unit.
// It holds one response until the receiver takes it. Depends on rmlu_pkg.
`default_nettype none

module rmlu_out_reg (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                load_i,
  input  wire rmlu_pkg::lock_rsp_t rsp_i,
  output logic                     ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output rmlu_pkg::lock_rsp_t      out_rsp_o
);
  import rmlu_pkg::*;

  logic      valid_q, valid_d;
  lock_rsp_t rsp_q;

  // A new response may enter when the register is empty or drains now.
  assign ready_o = !valid_q || !out_stall_i;
  assign valid_d = load_i ? 1'b1 : (out_stall_i ? valid_q : 1'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rsp_q <= rsp_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

`default_nettype wire

/* src/recursive_multicore_lock_unit.sv */
// Top level of the recursive multicore lock unit.
// It joins the input register, the lock logic and the result register.
// Depends on rmlu_pkg, rmlu_in_reg, rmlu_core and rmlu_out_reg.
`default_nettype none

// One recursive lock shared by the cores. Each request (enter, leave, abandon,
// suspend, resume, statistic read, statistic clear) is registered at the input,
// evaluated combinationally against the lock state and answered from a result
// register, and a new request can be accepted every cycle while the result register
// is not stalled; the state update of one request is seen by the next one. A core
// that finds the lock held by another core gets a busy answer and retries. Cores
// numbered CORES or above are refused. Depths saturate at the smaller of MAX_NEST
// and 255.
module recursive_multicore_lock_unit #(
  parameter int unsigned CORES    = 2,
  parameter int unsigned MAX_NEST = 255
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire rmlu_pkg::lock_req_t in_req_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output rmlu_pkg::lock_rsp_t      out_rsp_o
);
  import rmlu_pkg::*;

  logic       req_valid;
  lock_req_t  req;
  lock_rsp_t  rsp;
  lock_view_t view;
  logic       out_ready;
  logic       fire;

  // A request is evaluated when the result register can take its answer.
  assign fire = req_valid && out_ready;

  rmlu_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .take_i     (fire),
    .valid_o    (req_valid),
    .req_o      (req)
  );

  rmlu_core #(
    .CORES    (CORES),
    .MAX_NEST (MAX_NEST)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .req_i  (req),
    .rsp_o  (rsp),
    .view_o (view)
  );

  rmlu_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (fire),
    .rsp_i       (rsp),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_rsp_o   (out_rsp_o)
  );

  // Only the owning core has a nonzero depth, and only while it owns the lock.
  a_single_holder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(view.depth_nz) <= 1 && ((view.owner == 2'd0) == (view.depth_nz == '0)))
    else $error("lock depth and owner disagree");

  // An evaluated request always leaves a response behind.
  a_fire_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o)
    else $error("evaluated request produced no response");

  // A busy answer means another core holds the lock.
  a_busy_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.status == StatusBusy |->
      out_rsp_o.owner_word != 2'd0 && !out_rsp_o.held_by_caller)
    else $error("busy answer without a foreign owner");

  // A final leave releases the lock.
  a_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_rsp_o.restore_mask_valid |->
      out_rsp_o.owner_word == 2'd0 && out_rsp_o.caller_depth == 8'd0)
    else $error("final leave left the lock held");

endmodule

`default_nettype wire

/* test/recursive_multicore_lock_unit_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the recursive multicore lock unit.
// It holds its own model of the lock and its statistics, drives directed and random requests
// with random idle and stall cycles, and depends on rmlu_pkg and the lock unit RTL.

module recursive_multicore_lock_unit_tb;
  import rmlu_pkg::*;

  localparam int unsigned Cores       = 2;
  localparam int unsigned MaxNest     = 255;
  localparam int unsigned DepthCap    = (MaxNest < 255) ? MaxNest : 255;
  localparam int unsigned RandomItems = 700;
  localparam int unsigned LimitCycles = 200000;

  // Codes that the package does not name.
  localparam logic [2:0] ModeUndefined = 3'd7;
  localparam logic [3:0] StatUnused    = 4'd15;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  lock_req_t in_req    = '0;
  logic      out_valid;
  logic      out_stall = 1'b1;
  lock_rsp_t out_rsp;

  recursive_multicore_lock_unit #(
    .CORES   (Cores),
    .MAX_NEST(MaxNest)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_req_i   (in_req),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_rsp_o  (out_rsp)
  );

  // Mirror of the lock state; it works out the answer to each accepted request and
  // keeps the answers that are still due from the block.
  class lock_mirror;
    logic [1:0]  owner;
    logic [7:0]  depth[Cores];
    logic        saved_mask[Cores];
    logic [31:0] acquired_at[Cores];
    logic [31:0] wait_began[Cores];
    logic        waiting[Cores];
    logic [7:0]  last_suspended[Cores];
    logic [31:0] n_acquire, n_contention, n_recursion;
    logic [7:0]  deepest;
    logic [31:0] longest_hold, longest_wait;
    logic [31:0] n_detach, n_bad_suspend, n_bad_unlock;
    lock_rsp_t   answers_due[$];
    int          errors;

    function new();
      owner  = '0;
      errors = 0;
      for (int c = 0; c < Cores; c++) begin
        depth[c]          = '0;
        saved_mask[c]     = 1'b0;
        acquired_at[c]    = '0;
        wait_began[c]     = '0;
        waiting[c]        = 1'b0;
        last_suspended[c] = '0;
      end
      clear_statistics();
    endfunction

    function void clear_statistics();
      n_acquire     = '0;
      n_contention  = '0;
      n_recursion   = '0;
      deepest       = '0;
      longest_hold  = '0;
      longest_wait  = '0;
      n_detach      = '0;
      n_bad_suspend = '0;
      n_bad_unlock  = '0;
    endfunction

    function void raise_deepest(logic [7:0] d);
      if (d > deepest) deepest = d;
    endfunction

    function void record_hold(int c, logic [31:0] now);
      logic [31:0] held;
      held = now - acquired_at[c];
      if (held > longest_hold) longest_hold = held;
    endfunction

    // Taking the lock for a core that does not own it; a busy answer starts the wait clock.
    function status_e take_lock(int c, logic [31:0] now, logic mask);
      logic [31:0] waited;
      if (owner != 2'd0) begin
        if (!waiting[c]) begin
          waiting[c]    = 1'b1;
          wait_began[c] = now;
        end
        return StatusBusy;
      end
      waited = waiting[c] ? now - wait_began[c] : 32'd0;
      if (waited > longest_wait) longest_wait = waited;
      if (waiting[c]) n_contention++;
      waiting[c]     = 1'b0;
      owner          = 2'(c + 1);
      depth[c]       = 8'd1;
      saved_mask[c]  = mask;
      acquired_at[c] = now;
      n_acquire++;
      raise_deepest(8'd1);
      return StatusDone;
    endfunction

    function logic [31:0] read_statistic(logic [3:0] sel, int c);
      case (sel)
        StatAcquire:    return n_acquire;
        StatContention: return n_contention;
        StatRecursion:  return n_recursion;
        StatMaxDepth:   return 32'(deepest);
        StatHold:       return longest_hold;
        StatWait:       return longest_wait;
        StatDetach:     return n_detach;
        StatBadSuspend: return n_bad_suspend;
        StatBadUnlock:  return n_bad_unlock;
        StatOwner:      return 32'(owner);
        StatCoreDepth:  return 32'(depth[c]);
        default:        return 32'd0;
      endcase
    endfunction

    // Applies one accepted request and queues the answer it must produce.
    function void note_request(lock_req_t r);
      lock_rsp_t  e;
      int         c;
      logic [1:0] token;
      logic [7:0] d;
      e     = '0;
      c     = int'(r.core);
      token = 2'(c + 1);
      case (r.mode)
        ModeEnter: begin
          if (owner == token) begin
            if (depth[c] < DepthCap) depth[c]++;
            raise_deepest(depth[c]);
            n_recursion++;
          end else begin
            e.status = take_lock(c, r.now_us, r.mask_in);
          end
        end
        ModeLeave: begin
          if (owner != token || depth[c] == 8'd0) begin
            n_bad_unlock++;
            e.status = StatusIllegal;
          end else begin
            depth[c]--;
            if (depth[c] == 8'd0) begin
              record_hold(c, r.now_us);
              owner                = 2'd0;
              e.restore_mask_valid = 1'b1;
              e.restore_mask       = saved_mask[c];
            end
          end
        end
        ModeAbandon: begin
          if (owner == token) begin
            depth[c] = 8'd0;
            owner    = 2'd0;
          end
        end
        ModeSuspend: begin
          d = depth[c];
          if (d == 8'd0 || owner != token) begin
            n_bad_suspend++;
            e.status = StatusIllegal;
          end else begin
            record_hold(c, r.now_us);
            depth[c] = 8'd0;
            n_detach++;
            owner             = 2'd0;
            e.suspended_depth = d;
            last_suspended[c] = d;
          end
        end
        ModeResume: begin
          if (r.resume_level == 8'd0 || owner == token) begin
            n_bad_suspend++;
            e.status = StatusIllegal;
          end else begin
            e.status = take_lock(c, r.now_us, r.mask_in);
            if (e.status == StatusDone && r.resume_level > 8'd1) begin
              d        = (r.resume_level < DepthCap) ? r.resume_level : 8'(DepthCap);
              depth[c] = d;
              raise_deepest(d);
            end
          end
        end
        ModeReadStat:   e.stat_value = read_statistic(r.stat_select, c);
        ModeClearStats: clear_statistics();
        default: ;
      endcase
      e.held_by_caller = (owner == token);
      e.owner_word     = owner;
      e.caller_depth   = depth[c];
      answers_due.push_back(e);
    endfunction

    function void compare_field(string label, logic [31:0] want, logic [31:0] have);
      if (have !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, have);
        errors++;
      end
    endfunction

    // Compares one answer from the block with the oldest one due.
    function void check_answer(lock_rsp_t got);
      lock_rsp_t want;
      if (answers_due.size() == 0) begin
        $display("%0t: unexpected answer, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = answers_due.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("held_by_caller", want.held_by_caller, got.held_by_caller);
      compare_field("owner_word", want.owner_word, got.owner_word);
      compare_field("caller_depth", want.caller_depth, got.caller_depth);
      compare_field("suspended_depth", want.suspended_depth, got.suspended_depth);
      compare_field("restore_mask_valid", want.restore_mask_valid, got.restore_mask_valid);
      compare_field("restore_mask", want.restore_mask, got.restore_mask);
      compare_field("stat_value", want.stat_value, got.stat_value);
    endfunction
  endclass

  lock_mirror  mirror = new();
  logic [31:0] now_clock = 32'hFFFF_C000;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;
  int unsigned cycles = 0;

  // Free-running clock.
  initial begin
    forever #1 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Answers are checked at the edge where they are taken.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) mirror.check_answer(out_rsp);
  end

  // Receiver: stalls a random number of cycles before taking each answer.
  initial begin
    int n;
    wait (rst_n);
    forever begin
      if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
      n = rx_calm ? 0 : $urandom_range(0, 6);
      repeat (n) begin
        @(negedge clk);
        out_stall <= 1'b1;
      end
      @(negedge clk);
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Sends one request after an idle gap and waits until the block takes it.
  task automatic drive_request(input lock_req_t req, input int gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (in_stall);
    mirror.note_request(req);
  endtask

  // Drops valid and holds off until every answer has come back.
  task automatic wait_for_answers();
    @(negedge clk);
    in_valid <= 1'b0;
    while (mirror.answers_due.size() != 0) @(posedge clk);
  endtask

  task automatic issue(input logic [2:0] mode, input logic core, input logic [31:0] now,
                       input logic [7:0] rdepth, input logic mask, input logic [3:0] sel);
    lock_req_t r;
    r.mode         = mode;
    r.core         = core;
    r.now_us       = now;
    r.resume_level = rdepth;
    r.mask_in      = mask;
    r.stat_select  = sel;
    drive_request(r, $urandom_range(0, 6));
  endtask

  // Random request, biased so that the owner mostly leaves, nests and suspends its own lock.
  function automatic lock_req_t random_request();
    lock_req_t   r;
    int unsigned pick;
    logic [7:0]  kept;
    pick = $urandom_range(0, 99);
    if (pick < 30)      r.mode = ModeEnter;
    else if (pick < 52) r.mode = ModeLeave;
    else if (pick < 60) r.mode = ModeSuspend;
    else if (pick < 70) r.mode = ModeResume;
    else if (pick < 74) r.mode = ModeAbandon;
    else if (pick < 90) r.mode = ModeReadStat;
    else if (pick < 93) r.mode = ModeClearStats;
    else if (pick < 95) r.mode = ModeUndefined;
    else                r.mode = 3'($urandom);

    r.core = 1'($urandom);
    if (mirror.owner != 2'd0 && $urandom_range(0, 99) < 70) r.core = 1'(mirror.owner - 2'd1);

    // Time mostly creeps forward and can wrap; now and then it jumps anywhere.
    if ($urandom_range(0, 32) == 0) now_clock = $urandom;
    else now_clock = now_clock + $urandom_range(0, 50);
    r.now_us = now_clock;

    kept = mirror.last_suspended[r.core];
    pick = $urandom_range(0, 9);
    if (pick < 5 && kept != 8'd0) r.resume_level = kept;
    else if (pick == 5)           r.resume_level = 8'd0;
    else if (pick == 6)           r.resume_level = 8'hFF;
    else if (pick == 7)           r.resume_level = 8'($urandom);
    else                          r.resume_level = 8'($urandom_range(1, 4));

    r.mask_in     = 1'($urandom);
    r.stat_select = 4'($urandom);
    return r;
  endfunction

  // Main sequence: reset, directed requests, then random traffic.
  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // A statistic read and illegal requests on an idle lock.
    issue(ModeReadStat, 1'b0, 32'd0, 8'd0, 1'b0, StatOwner);
    issue(ModeLeave, 1'b0, 32'd1, 8'd0, 1'b0, StatAcquire);
    issue(ModeSuspend, 1'b1, 32'd2, 8'd0, 1'b0, StatAcquire);
    issue(ModeResume, 1'b1, 32'd10, 8'd0, 1'b0, StatAcquire);
    // Nesting by core 0 while core 1 waits and tries illegal moves.
    issue(ModeEnter, 1'b0, 32'd100, 8'd0, 1'b1, StatAcquire);
    issue(ModeEnter, 1'b0, 32'd101, 8'd0, 1'b0, StatAcquire);
    issue(ModeEnter, 1'b1, 32'd110, 8'd0, 1'b0, StatAcquire);
    issue(ModeEnter, 1'b1, 32'd120, 8'd0, 1'b0, StatAcquire);
    issue(ModeLeave, 1'b1, 32'd125, 8'd0, 1'b0, StatAcquire);
    issue(ModeAbandon, 1'b1, 32'd126, 8'd0, 1'b0, StatAcquire);
    issue(ModeResume, 1'b0, 32'd127, 8'd3, 1'b0, StatAcquire);
    // Final leave hands back the saved mask; the waiter then gets the lock.
    issue(ModeLeave, 1'b0, 32'd130, 8'd0, 1'b0, StatAcquire);
    issue(ModeLeave, 1'b0, 32'd140, 8'd0, 1'b0, StatAcquire);
    issue(ModeEnter, 1'b1, 32'd200, 8'd0, 1'b0, StatAcquire);
    // Suspend at the top of the time range, resume to full depth, saturated enter.
    issue(ModeSuspend, 1'b1, 32'hFFFF_FFFF, 8'd0, 1'b0, StatAcquire);
    issue(ModeResume, 1'b0, 32'd5, 8'hFF, 1'b1, StatAcquire);
    issue(ModeEnter, 1'b0, 32'd6, 8'd0, 1'b0, StatAcquire);
    issue(ModeResume, 1'b1, 32'd7, 8'd1, 1'b1, StatAcquire);
    issue(ModeAbandon, 1'b0, 32'd8, 8'd0, 1'b0, StatAcquire);
    issue(ModeUndefined, 1'b1, 32'd9, 8'hFF, 1'b1, StatUnused);
    issue(ModeReadStat, 1'b0, 32'd10, 8'd0, 1'b0, StatHold);
    issue(ModeReadStat, 1'b1, 32'd11, 8'd0, 1'b0, StatMaxDepth);
    issue(ModeReadStat, 1'b1, 32'd12, 8'd0, 1'b0, StatUnused);
    issue(ModeClearStats, 1'b0, 32'd13, 8'd0, 1'b0, StatAcquire);
    issue(ModeReadStat, 1'b1, 32'd14, 8'd0, 1'b0, StatWait);
    wait_for_answers();

    for (int i = 0; i < RandomItems; i++) begin
      if (i % 100 == 50) wait_for_answers();
      if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
      drive_request(random_request(), tx_calm ? 0 : $urandom_range(0, 6));
    end
    wait_for_answers();
    repeat (8) @(posedge clk);

    if (mirror.errors == 0 && mirror.answers_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* files.f */
src/rmlu_pkg.sv
src/rmlu_in_reg.sv
src/rmlu_core.sv
src/rmlu_out_reg.sv
src/recursive_multicore_lock_unit.sv
test/recursive_multicore_lock_unit_tb.sv
